@@ design/sha1_pkg.sv @@
package sha1_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;
  } sha1_in_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
    logic [31:0] digest_e;
  } sha1_out_t;

  // word source for the block buffer
  typedef enum logic [2:0] {
    SRC_DATA,
    SRC_PAD_WORD,
    SRC_PAD_ONLY,
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } sha1_src_e;

  // controller to datapath
  typedef struct packed {
    logic       push;      // store a word in the block buffer
    sha1_src_e  src;
    logic       add_len;   // update running byte count
    logic       init_run;  // load working vars, start of compression
    logic       round;     // run one round
    logic [6:0] rnd;       // round number
    logic       fold;      // add working vars into chain
    logic       reinit;    // chain, count back to initial values
  } sha1_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] fill;      // words held in block buffer
  } sha1_sts_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0  = 32'h5A827999;
  localparam logic [31:0] K1  = 32'h6ED9EBA1;
  localparam logic [31:0] K2  = 32'h8F1BBCDC;
  localparam logic [31:0] K3  = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [6:0]  LAST_ROUND = 7'd79;

endpackage

@@ design/sha1_datapath.sv @@
module sha1_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::sha1_in_t  item_i,
  input  sha1_pkg::sha1_cmd_t cmd_i,
  output sha1_pkg::sha1_sts_t sts_o,
  output sha1_pkg::sha1_out_t digest_o
);
  import sha1_pkg::*;

  logic [31:0] chain_q [5];
  logic [31:0] w_q [16];        // block buffer, reused as schedule window
  logic [3:0]  fill_q;
  logic [60:0] bytes_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;

  logic [2:0]  vb;
  logic [31:0] keep, pad_bits, src_word, f, k, t, w_new, w_cur;
  logic [63:0] bitlen;

  always_comb begin
    vb = (item_i.valid_bytes > 3'd4) ? 3'd4 : item_i.valid_bytes;
    keep = ~(32'hFFFFFFFF >> {vb, 3'b000});
    pad_bits = {24'd0, PAD_BYTE} << {(3'd3 - vb[1:0]), 3'b000};
    bitlen = {bytes_q, 3'b000};
    case (cmd_i.src)
      SRC_DATA:     src_word = item_i.data_word;
      SRC_PAD_WORD: src_word = {PAD_BYTE, 24'd0};
      SRC_PAD_ONLY: src_word = (item_i.data_word & keep) | pad_bits;
      SRC_ZERO:     src_word = '0;
      SRC_LEN_HI:   src_word = bitlen[63:32];
      SRC_LEN_LO:   src_word = bitlen[31:0];
      default:      src_word = '0;
    endcase
    // schedule: window holds w[r..r+15] at w_q[0..15]
    w_cur = w_q[0];
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_new[30:0], w_new[31]};
    if (cmd_i.rnd < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = K0;
    end else if (cmd_i.rnd < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = K1;
    end else if (cmd_i.rnd < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q; k = K3;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bytes_q <= '0;
      chain_q[0] <= IV0; chain_q[1] <= IV1; chain_q[2] <= IV2;
      chain_q[3] <= IV3; chain_q[4] <= IV4;
    end else begin
      if (cmd_i.push) fill_q <= fill_q + 4'd1;
      if (cmd_i.add_len) begin
        if (item_i.last) bytes_q <= bytes_q + 61'(vb);
        else bytes_q <= bytes_q + 61'd4;
      end
      if (cmd_i.fold) begin
        chain_q[0] <= chain_q[0] + a_q; chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q; chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
      if (cmd_i.reinit) begin
        bytes_q <= '0;
        fill_q <= '0;
        chain_q[0] <= IV0; chain_q[1] <= IV1; chain_q[2] <= IV2;
        chain_q[3] <= IV3; chain_q[4] <= IV4;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) w_q[fill_q] <= src_word;
    if (cmd_i.init_run) begin
      a_q <= chain_q[0]; b_q <= chain_q[1]; c_q <= chain_q[2];
      d_q <= chain_q[3]; e_q <= chain_q[4];
    end
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      a_q <= t; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q; e_q <= d_q;
    end
  end

  assign sts_o.fill = fill_q;
  assign digest_o = '{chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};

endmodule

@@ design/sha1_ctrl.sv @@
module sha1_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  input  logic                in_full_i,  // last word with four bytes
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sha1_pkg::sha1_sts_t sts_i,
  output sha1_pkg::sha1_cmd_t cmd_o
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_FILL, ST_RUN, ST_FOLD, ST_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [6:0] rnd_q, rnd_d;
  logic       fin_q, fin_d;    // message ends after padding
  logic       xtra_q, xtra_d;  // current run is followed by an extra length block
  logic       pad_q, pad_d;    // pad word still owed after this run
  logic       accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q; rnd_d = rnd_q; fin_d = fin_q; xtra_d = xtra_q; pad_d = pad_q;
    cmd_o = '0;
    cmd_o.src = SRC_DATA;
    cmd_o.rnd = rnd_q;
    case (state_q)
      ST_IDLE: if (accept) begin
        cmd_o.push = 1'b1; cmd_o.add_len = 1'b1;
        cmd_o.src = (in_last_i && !in_full_i) ? SRC_PAD_ONLY : SRC_DATA;
        fin_d = in_last_i;
        xtra_d = 1'b0;
        if (sts_i.fill == 4'd15) begin
          state_d = ST_RUN; cmd_o.init_run = 1'b1; rnd_d = '0;
          // last word closes a block: length, and the pad word after a full word, go into a new one
          xtra_d = in_last_i;
          pad_d = in_last_i && in_full_i;
        end else if (in_last_i) begin
          state_d = in_full_i ? ST_PAD : ST_FILL;
        end
      end
      ST_PAD: begin
        // pad word after a full last word; fill may be 0 after a run
        cmd_o.push = 1'b1; cmd_o.src = SRC_PAD_WORD;
        pad_d = 1'b0;
        if (sts_i.fill == 4'd15) begin
          state_d = ST_RUN; cmd_o.init_run = 1'b1; rnd_d = '0; xtra_d = 1'b1;
        end else state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.push = 1'b1;
        if (xtra_q) cmd_o.src = SRC_ZERO;
        else if (sts_i.fill == 4'd14) cmd_o.src = SRC_LEN_HI;
        else if (sts_i.fill == 4'd15) cmd_o.src = SRC_LEN_LO;
        else cmd_o.src = SRC_ZERO;
        if (sts_i.fill == 4'd15) begin
          state_d = ST_RUN; cmd_o.init_run = 1'b1; rnd_d = '0;
        end
      end
      ST_RUN: begin
        cmd_o.round = 1'b1;
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == LAST_ROUND) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (!fin_q) state_d = ST_IDLE;
        else if (xtra_q) begin
          // pad went into a full block, or is still owed; length block follows
          xtra_d = 1'b0; state_d = pad_q ? ST_PAD : ST_FILL;
        end else state_d = ST_OUT;
      end
      ST_OUT: if (!out_stall_i) begin
        cmd_o.reinit = 1'b1; fin_d = 1'b0; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // fill when padding lands past word 13 needs an extra block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; rnd_q <= '0; fin_q <= 1'b0; xtra_q <= 1'b0; pad_q <= 1'b0;
    end else begin
      state_q <= state_d; rnd_q <= rnd_d; fin_q <= fin_d; pad_q <= pad_d;
      if (state_q == ST_FILL && state_d == ST_FILL && sts_i.fill == 4'd13 && !xtra_q)
        xtra_q <= 1'b0;
      else if ((state_q == ST_IDLE || state_q == ST_PAD) && state_d == ST_FILL)
        xtra_q <= (sts_i.fill == 4'd14);
      else xtra_q <= xtra_d;
    end
  end

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> rnd_q <= LAST_ROUND) else $error("round overrun");
  a_fold_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FOLD |-> $past(state_q) == ST_RUN) else $error("fold order");
  a_out_needs_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fin_q) else $error("digest without last");

endmodule

@@ design/sha1_hash_engine_core.sv @@
// channel | direction | handshake          | payload
// in      | input     | in_valid_i/stall_o | in_data_i  (sha1_in_t)
// out     | output    | out_valid_o/stall_i| out_data_o (sha1_out_t)
//
// One round per cycle: a block takes 16 word loads, then 80 rounds and a
// fold; no new input word is taken until the fold is done.
// Last word: padding and length words go in one per cycle, then one or
// two compressions, then the digest waits in the chain registers.
// Input stalls whenever the engine is not idle. Reset is asynchronous and
// restores the initial chaining values; no clearing pass is needed.
module sha1_hash_engine_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sha1_pkg::sha1_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sha1_pkg::sha1_out_t out_data_o
);
  import sha1_pkg::*;

  sha1_cmd_t cmd;
  sha1_sts_t sts;

  sha1_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_last_i  (in_data_i.last),
    .in_full_i  (in_data_i.valid_bytes >= 3'd4),
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sha1_datapath u_dp (
    .clk_i, .rst_ni,
    .item_i   (in_data_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .digest_o (out_data_o)
  );

endmodule
